// ----- src/ccrp_pkg.sv -----
// Package for the ChaCha20 reseeding keystream pool.
// Holds shared types, constants and the quarter-round function; no dependencies.
`default_nettype none
package ccrp_pkg;

    localparam int unsigned DOUBLE_ROUNDS_DEFAULT = 10;
    localparam int unsigned COUNT_W = 25;
    localparam logic [COUNT_W-1:0] INTERVAL_RESET = 25'd1048576;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_BLOCK = 1'b1;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;
    typedef word_t [3:0] quad_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } core_state_t;

    typedef struct packed {
        logic [255:0] key;
        logic [63:0]  index;
        logic         unseeded;
    } job_t;

    function automatic word_t rotl(input word_t v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic quad_t quarter(input quad_t q);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b;
        d = rotl(d ^ a, 16);
        c = c + d;
        b = rotl(b ^ c, 12);
        a = a + b;
        d = rotl(d ^ a, 8);
        c = c + d;
        b = rotl(b ^ c, 7);
        quarter = {d, c, b, a};
    endfunction

endpackage
`default_nettype wire

// ----- src/ccrp_front.sv -----
// Front part of the keystream pool: accepts transactions, keeps key, index and count.
// Depends on ccrp_pkg; pushes one block job per block transaction into the queue.
`default_nettype none
module ccrp_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [ccrp_pkg::COUNT_W-1:0] cfg_wdata,
    input  wire logic                       valid,
    output      logic                       ready,
    input  wire logic                       req_type,
    input  wire logic [6:0]                 take_bytes,
    input  wire logic                       chunk_end,
    input  wire logic [63:0]                entropy_a,
    input  wire logic [63:0]                entropy_b,
    input  wire logic [63:0]                entropy_c,
    input  wire logic [63:0]                entropy_d,
    output      logic                       job_valid,
    input  wire logic                       job_ready,
    output      ccrp_pkg::job_t             job
);
    import ccrp_pkg::*;

    logic [255:0]       key_reg;
    logic [255:0]       key_next;
    logic [63:0]        index_reg;
    logic [63:0]        index_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               seeded_reg;
    logic               seeded_next;
    logic [COUNT_W-1:0] interval_reg;
    logic [255:0]       ent;
    logic [6:0]         take;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] sat;
    logic               accept;

    assign ent = {entropy_d, entropy_c, entropy_b, entropy_a};
    assign ready = (req_type == REQ_SEED) ? 1'b1 : job_ready;
    assign accept = valid && ready;
    assign job_valid = valid && (req_type == REQ_BLOCK);
    assign job = '{key: key_reg, index: index_reg, unseeded: !seeded_reg};

    always_comb
    begin
        take = (take_bytes > BLOCK_BYTES) ? BLOCK_BYTES : take_bytes;
        sum = {1'b0, count_reg} + {{(COUNT_W-6){1'b0}}, take};
        sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        key_next = key_reg;
        index_next = index_reg;
        count_next = count_reg;
        seeded_next = seeded_reg;
        if (accept)
        begin
            if (req_type == REQ_SEED)
            begin
                key_next = ent;
                index_next = '0;
                count_next = '0;
                seeded_next = 1'b1;
            end
            else
            begin
                index_next = index_reg + 64'd1;
                count_next = sat;
                if (chunk_end && (sat >= interval_reg))
                begin
                    key_next = key_reg ^ ent;
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            index_reg <= '0;
            count_reg <= '0;
            seeded_reg <= 1'b0;
            interval_reg <= INTERVAL_RESET;
        end
        else
        begin
            key_reg <= key_next;
            index_reg <= index_next;
            count_reg <= count_next;
            seeded_reg <= seeded_next;
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/ccrp_queue.sv -----
// Short job queue between the front and the block core of the keystream pool.
// Depends on ccrp_pkg for the job type.
`default_nettype none
module ccrp_queue #(
    parameter int unsigned DEPTH = ccrp_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output      logic           in_ready,
    input  wire ccrp_pkg::job_t in_job,
    output      logic           out_valid,
    input  wire logic           out_ready,
    output      ccrp_pkg::job_t out_job
);
    import ccrp_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t          mem [DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready = (cnt_reg != AW'(0) + (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_job = mem[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule
`default_nettype wire

// ----- src/ccrp_core.sv -----
// Back part of the keystream pool: ChaCha20 block function on a shared round unit.
// Depends on ccrp_pkg; emits eight 64-bit words per job through an output register.
`default_nettype none
module ccrp_core #(
    parameter int unsigned DOUBLE_ROUNDS = ccrp_pkg::DOUBLE_ROUNDS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output      logic           job_ready,
    input  wire ccrp_pkg::job_t job,
    output      logic           out_valid,
    input  wire logic           out_ready,
    output      logic [63:0]    keystream_word,
    output      logic [2:0]     word_index,
    output      logic           last_word,
    output      logic           unseeded
);
    import ccrp_pkg::*;

    localparam int unsigned ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int unsigned RW = $clog2(ROUNDS + 1);

    core_state_t state_reg;
    core_state_t state_next;
    state_t      x_reg;
    state_t      x_next;
    state_t      init_reg;
    state_t      init_job;
    state_t      rnd;
    logic [RW-1:0] rcnt_reg;
    logic [RW-1:0] rcnt_next;
    logic [2:0]  widx_reg;
    logic [2:0]  widx_next;
    logic        uns_reg;
    logic        uns_next;
    logic        ov_reg;
    logic        ov_next;
    logic [63:0] ow_reg;
    logic [63:0] ow_next;
    logic [2:0]  oi_reg;
    logic [2:0]  oi_next;
    logic        ou_reg;
    logic        ou_next;
    logic        load;
    logic        slot_free;
    logic        emit;

    assign slot_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign keystream_word = ow_reg;
    assign word_index = oi_reg;
    assign last_word = (oi_reg == 3'd7);
    assign unseeded = ou_reg;

    always_comb
    begin
        init_job[0] = 32'h61707865;
        init_job[1] = 32'h3320646e;
        init_job[2] = 32'h79622d32;
        init_job[3] = 32'h6b206574;
        for (int i = 0; i < 8; i++)
        begin
            init_job[4 + i] = job.key[32*i +: 32];
        end
        init_job[12] = job.index[31:0];
        init_job[13] = job.index[63:32];
        init_job[14] = '0;
        init_job[15] = '0;
    end

    always_comb
    begin
        quad_t q;
        rnd = x_reg;
        for (int c = 0; c < 4; c++)
        begin
            if (!rcnt_reg[0])
            begin
                q = quarter({x_reg[12 + c], x_reg[8 + c], x_reg[4 + c], x_reg[c]});
                rnd[c] = q[0];
                rnd[4 + c] = q[1];
                rnd[8 + c] = q[2];
                rnd[12 + c] = q[3];
            end
            else
            begin
                q = quarter({x_reg[12 + (c + 3) % 4], x_reg[8 + (c + 2) % 4],
                             x_reg[4 + (c + 1) % 4], x_reg[c]});
                rnd[c] = q[0];
                rnd[4 + (c + 1) % 4] = q[1];
                rnd[8 + (c + 2) % 4] = q[2];
                rnd[12 + (c + 3) % 4] = q[3];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rcnt_reg == RW'(ROUNDS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free && widx_reg == 3'd7)
                begin
                    state_next = job_valid ? ST_ROUND : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit = (state_reg == ST_EMIT) && slot_free;
        load = job_valid && ((state_reg == ST_IDLE) || (emit && widx_reg == 3'd7));
        job_ready = load;
        x_next = x_reg;
        rcnt_next = rcnt_reg;
        widx_next = widx_reg;
        uns_next = uns_reg;
        ov_next = ov_reg && !out_ready;
        ow_next = ow_reg;
        oi_next = oi_reg;
        ou_next = ou_reg;
        case (state_reg)
            ST_ROUND:
            begin
                x_next = rnd;
                rcnt_next = rcnt_reg + RW'(1);
            end
            ST_FINAL:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    x_next[i] = x_reg[i] + init_reg[i];
                end
                widx_next = '0;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    ov_next = 1'b1;
                    ow_next = {x_reg[2*widx_reg + 1], x_reg[2*widx_reg]};
                    oi_next = widx_reg;
                    ou_next = uns_reg;
                    widx_next = widx_reg + 3'd1;
                end
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            x_next = init_job;
            rcnt_next = '0;
            uns_next = job.unseeded;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            init_reg <= init_job;
        end
        x_reg <= x_next;
        uns_reg <= uns_next;
        ow_reg <= ow_next;
        oi_reg <= oi_next;
        ou_reg <= ou_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rcnt_reg <= '0;
            widx_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rcnt_reg <= rcnt_next;
            widx_reg <= widx_next;
            ov_reg <= ov_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/chacha20_reseeding_keystream_pool.sv -----
// Top level of the ChaCha20 reseeding keystream pool.
// Depends on ccrp_pkg, ccrp_front, ccrp_queue and ccrp_core.
//
// A seed transaction is never stalled and yields nothing. A block transaction
// yields eight 64-bit keystream words. The block core runs one ChaCha round per cycle
// on a single shared round unit; after the rounds it adds the initial state and then
// emits the eight words through an output register, which holds while the sink is not
// ready. Key, index and reseed count update when a transaction is accepted, and a
// two-entry job queue lets the front keep taking transactions while the core works.
// The user must write the reseed interval while the block is idle; it is not enforced.
`default_nettype none
module chacha20_reseeding_keystream_pool #(
    parameter int unsigned DOUBLE_ROUNDS = ccrp_pkg::DOUBLE_ROUNDS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ccrp_pkg::COUNT_W-1:0] cfg_wdata,
    input  wire logic                         in_valid,
    output      logic                         in_ready,
    input  wire logic                         req_type,
    input  wire logic [6:0]                   take_bytes,
    input  wire logic                         chunk_end,
    input  wire logic [63:0]                  entropy_a,
    input  wire logic [63:0]                  entropy_b,
    input  wire logic [63:0]                  entropy_c,
    input  wire logic [63:0]                  entropy_d,
    output      logic                         out_valid,
    input  wire logic                         out_ready,
    output      logic [63:0]                  keystream_word,
    output      logic [2:0]                   word_index,
    output      logic                         last_word,
    output      logic                         unseeded
);
    import ccrp_pkg::*;

    logic q_in_valid;
    logic q_in_ready;
    job_t q_in_job;
    logic q_out_valid;
    logic q_out_ready;
    job_t q_out_job;

    ccrp_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .valid(in_valid), .ready(in_ready), .req_type(req_type),
        .take_bytes(take_bytes), .chunk_end(chunk_end),
        .entropy_a(entropy_a), .entropy_b(entropy_b),
        .entropy_c(entropy_c), .entropy_d(entropy_d),
        .job_valid(q_in_valid), .job_ready(q_in_ready), .job(q_in_job)
    );

    ccrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_in_valid), .in_ready(q_in_ready), .in_job(q_in_job),
        .out_valid(q_out_valid), .out_ready(q_out_ready), .out_job(q_out_job)
    );

    ccrp_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_out_valid), .job_ready(q_out_ready), .job(q_out_job),
        .out_valid(out_valid), .out_ready(out_ready),
        .keystream_word(keystream_word), .word_index(word_index),
        .last_word(last_word), .unseeded(unseeded)
    );

endmodule
`default_nettype wire

// ----- src/ccrp_checker.sv -----
// Port-level checker for the keystream pool, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module ccrp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] keystream_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && word_index != 3'd7) |=>
            (!out_valid || word_index == $past(word_index) + 3'd1))
        else $error("keystream words out of order");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && word_index == 3'd7) |=>
            (!out_valid || word_index == 3'd0))
        else $error("block does not start at word zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(keystream_word)))
        else $error("stalled word changed");

endmodule

bind chacha20_reseeding_keystream_pool ccrp_checker u_ccrp_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .keystream_word(keystream_word), .word_index(word_index), .last_word(last_word)
);
`default_nettype wire

// ----- sim/tb_chacha20_reseeding_keystream_pool.sv -----
// Testbench for the ChaCha20 reseeding keystream pool.
// Predicts each keystream word from its own ChaCha20 model and checks it; depends on ccrp_pkg.
`default_nettype none
module tb_chacha20_reseeding_keystream_pool;
    import ccrp_pkg::*;

    typedef struct {
        logic        kind;
        logic [6:0]  take;
        logic        chunk;
        logic [63:0] ent [4];
    } pool_req_t;

    typedef struct {
        logic [63:0] ks;
        logic [2:0]  idx;
        logic        last;
        logic        unseed;
    } ks_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic req_type;
    logic [6:0] take_bytes;
    logic chunk_end;
    logic [63:0] entropy_a;
    logic [63:0] entropy_b;
    logic [63:0] entropy_c;
    logic [63:0] entropy_d;
    logic out_valid;
    logic out_ready;
    logic [63:0] keystream_word;
    logic [2:0] word_index;
    logic last_word;
    logic unseeded;

    pool_req_t pending_reqs[$];
    ks_word_t expected_words[$];
    int fail_count;
    bit calm;
    bit in_taken;

    logic [63:0] key_model [4];
    logic [63:0] index_model;
    logic [COUNT_W-1:0] count_model;
    logic seeded_model;
    logic [COUNT_W-1:0] interval_model;

    chacha20_reseeding_keystream_pool dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .take_bytes(take_bytes),
        .chunk_end(chunk_end),
        .entropy_a(entropy_a),
        .entropy_b(entropy_b),
        .entropy_c(entropy_c),
        .entropy_d(entropy_d),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .keystream_word(keystream_word),
        .word_index(word_index),
        .last_word(last_word),
        .unseeded(unseeded)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic logic [31:0] rol32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix(ref logic [31:0] x [16], input int a, int b, int c, int d);
        x[a] = x[a] + x[b];
        x[d] = rol32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d];
        x[b] = rol32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b];
        x[d] = rol32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d];
        x[b] = rol32(x[b] ^ x[c], 7);
    endfunction

    task automatic apply_request(input pool_req_t r);
        logic [31:0] init [16];
        logic [31:0] x [16];
        ks_word_t w;
        int unsigned take;
        int unsigned sum;
        if (r.kind == REQ_SEED)
        begin
            for (int i = 0; i < 4; i++)
                key_model[i] = r.ent[i];
            index_model = '0;
            count_model = '0;
            seeded_model = 1'b1;
            return;
        end
        init[0] = 32'h61707865;
        init[1] = 32'h3320646e;
        init[2] = 32'h79622d32;
        init[3] = 32'h6b206574;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = key_model[i][31:0];
            init[5 + 2 * i] = key_model[i][63:32];
        end
        init[12] = index_model[31:0];
        init[13] = index_model[63:32];
        init[14] = '0;
        init[15] = '0;
        x = init;
        for (int i = 0; i < DOUBLE_ROUNDS_DEFAULT; i++)
        begin
            mix(x, 0, 4, 8, 12);
            mix(x, 1, 5, 9, 13);
            mix(x, 2, 6, 10, 14);
            mix(x, 3, 7, 11, 15);
            mix(x, 0, 5, 10, 15);
            mix(x, 1, 6, 11, 12);
            mix(x, 2, 7, 8, 13);
            mix(x, 3, 4, 9, 14);
        end
        for (int k = 0; k < 8; k++)
        begin
            w.ks = {x[2 * k + 1] + init[2 * k + 1], x[2 * k] + init[2 * k]};
            w.idx = k[2:0];
            w.last = (k == 7);
            w.unseed = ~seeded_model;
            expected_words.push_back(w);
        end
        index_model = index_model + 64'd1;
        take = (r.take > BLOCK_BYTES) ? BLOCK_BYTES : r.take;
        sum = count_model + take;
        count_model = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
        if (r.chunk && count_model >= interval_model)
        begin
            for (int i = 0; i < 4; i++)
                key_model[i] ^= r.ent[i];
            count_model = '0;
        end
    endtask

    function automatic pool_req_t make_req(logic kind, logic [6:0] take, logic chunk);
        pool_req_t r;
        r.kind = kind;
        r.take = take;
        r.chunk = chunk;
        for (int i = 0; i < 4; i++)
            r.ent[i] = {$urandom, $urandom};
        return r;
    endfunction

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_taken)
            begin
                if (in_taken)
                    apply_request(pending_reqs.pop_front());
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 17))
                begin
                    req_type <= pending_reqs[0].kind;
                    take_bytes <= pending_reqs[0].take;
                    chunk_end <= pending_reqs[0].chunk;
                    entropy_a <= pending_reqs[0].ent[0];
                    entropy_b <= pending_reqs[0].ent[1];
                    entropy_c <= pending_reqs[0].ent[2];
                    entropy_d <= pending_reqs[0].ent[3];
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= calm || $urandom_range(99) >= 17;
        end
    end

    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("keystream word with no expectation waiting");
                fail_count++;
            end
            else
            begin
                ks_word_t e;
                e = expected_words.pop_front();
                if (keystream_word !== e.ks)
                begin
                    $error("keystream_word expected %h actual %h", e.ks, keystream_word);
                    fail_count++;
                end
                if (word_index !== e.idx)
                begin
                    $error("word_index expected %0d actual %0d", e.idx, word_index);
                    fail_count++;
                end
                if (last_word !== e.last)
                begin
                    $error("last_word expected %0b actual %0b", e.last, last_word);
                    fail_count++;
                end
                if (unseeded !== e.unseed)
                begin
                    $error("unseeded expected %0b actual %0b", e.unseed, unseeded);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_interval(logic [COUNT_W-1:0] v);
        @(negedge clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        interval_model = v;
    endtask

    task automatic random_phase(int n);
        pool_req_t r;
        for (int i = 0; i < n; i++)
        begin
            r = make_req($urandom_range(99) >= 8 ? REQ_BLOCK : REQ_SEED,
                         $urandom_range(99) < 80 ? 7'($urandom_range(64)) : 7'($urandom),
                         $urandom_range(99) < 40);
            pending_reqs.push_back(r);
        end
    endtask

    initial
    begin
        fail_count = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_type = 1'b0;
        take_bytes = '0;
        chunk_end = 1'b0;
        entropy_a = '0;
        entropy_b = '0;
        entropy_c = '0;
        entropy_d = '0;
        for (int i = 0; i < 4; i++)
            key_model[i] = '0;
        index_model = '0;
        count_model = '0;
        seeded_model = 1'b0;
        interval_model = INTERVAL_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_reqs.push_back(make_req(REQ_BLOCK, 7'd0, 1'b0));
        pending_reqs.push_back(make_req(REQ_BLOCK, 7'd127, 1'b1));
        drain();
        set_interval(25'd0);
        pending_reqs.push_back(make_req(REQ_SEED, 7'd127, 1'b1));
        pending_reqs.push_back(make_req(REQ_BLOCK, 7'd0, 1'b1));
        pending_reqs.push_back(make_req(REQ_BLOCK, 7'd64, 1'b1));
        pending_reqs.push_back(make_req(REQ_BLOCK, 7'd65, 1'b0));
        pending_reqs[$].ent[0] = '1;
        pending_reqs.push_back(make_req(REQ_SEED, 7'd0, 1'b0));
        pending_reqs[$].ent[1] = '1;
        pending_reqs[$].ent[2] = '1;
        pending_reqs[$].ent[3] = '1;
        pending_reqs.push_back(make_req(REQ_BLOCK, 7'd64, 1'b1));
        drain();
        set_interval(25'd64);
        for (int i = 0; i < 4; i++)
            pending_reqs.push_back(make_req(REQ_BLOCK, 7'd32, i[0]));
        pending_reqs.push_back(make_req(REQ_BLOCK, 7'd64, 1'b1));
        drain();
        set_interval(COUNT_MAX);
        pending_reqs.push_back(make_req(REQ_BLOCK, 7'd64, 1'b1));
        drain();

        set_interval(25'd64);
        random_phase(60);
        drain();
        set_interval(25'd300);
        calm = 1'b1;
        random_phase(50);
        drain();
        calm = 1'b0;
        set_interval(25'd16777216);
        random_phase(40);
        drain();
        set_interval(25'd17);
        random_phase(50);
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
src/ccrp_pkg.sv
src/ccrp_front.sv
src/ccrp_queue.sv
src/ccrp_core.sv
src/chacha20_reseeding_keystream_pool.sv
src/ccrp_checker.sv
sim/tb_chacha20_reseeding_keystream_pool.sv
